>>> design/lzrd_pkg.sv
// Shared types and constants of the LZ/RLE token decompressor.
// Used by the top level and by the port checker; depends on nothing.
package lzrd_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [15:0] LIMIT_RESET = 16'hc000;

    typedef logic [2:0] status_t;
    localparam status_t ST_DATA  = 3'd0;
    localparam status_t ST_END   = 3'd1;
    localparam status_t ST_BAD   = 3'd2;
    localparam status_t ST_TRUNC = 3'd3;
    localparam status_t ST_LIMIT = 3'd4;

    typedef logic [1:0] phase_t;
    localparam phase_t PH_TOKEN = 2'd0;
    localparam phase_t PH_DIST  = 2'd1;
    localparam phase_t PH_LIT   = 2'd2;
    localparam phase_t PH_FILL  = 2'd3;

    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

endpackage

>>> design/lzrd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
module lzrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lz_rle_token_decompressor.sv
// A request is decoded in the cycle it is accepted; each decoded byte is then written to
//   the history RAM and the pair accumulator and leaves through the output register, a
//   back reference first reading its bytes from the history RAM. One decoded byte per
//   cycle (history RAM write port) while the result channel does not stall; a new request
//   is taken only in the idle state, once the previous one is fully decoded and flushed.
// Reset: synchronous active-low aresetn clears control state and loads output_limit 0xc000.
module lz_rle_token_decompressor
    import lzrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // packed byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_first_of_stream,
    input  logic        s_last_of_stream,
    // decoded results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_a,
    output logic [7:0]  m_byte_b,
    output logic [1:0]  m_byte_count,
    output logic        m_run_last,
    output logic [2:0]  m_status,
    // output_limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // Sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;  // take the next packed byte
    localparam logic [1:0] S_COPY  = 2'd1;  // back reference: read history, write it back
    localparam logic [1:0] S_FILL  = 2'd2;  // fill or literal: write the held byte
    localparam logic [1:0] S_FLUSH = 2'd3;  // send the partial pair and any status

    logic [1:0]         state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         held_reg, held_next;
    logic [5:0]         lit_left_reg, lit_left_next;
    logic               finished_reg, finished_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [16:0]        pc_reg, pc_next;
    logic [15:0]        limit_reg, limit_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [HIST_AW-1:0] src_reg, src_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         fill_reg, fill_next;
    status_t            status_reg, status_next;

    // Pair accumulator: up to two bytes waiting to leave as one result
    logic [1:0]         acc_n_reg, acc_n_next;
    logic [7:0]         acc_a_reg, acc_a_next;
    logic [7:0]         acc_b_reg, acc_b_next;

    // Forwarding of a write that lands on the address read in the same cycle
    logic               fwd_hit_reg;
    logic [7:0]         fwd_data_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_a_reg, m_byte_a_next;
    logic [7:0]         m_byte_b_reg, m_byte_b_next;
    logic [1:0]         m_count_reg, m_count_next;
    logic               m_last_reg, m_last_next;
    status_t            m_status_reg, m_status_next;

    logic               s_accept;
    logic               out_free;
    logic               emit_pair;
    logic               can_put;
    logic               put;
    logic [7:0]         put_byte;
    logic [7:0]         copy_byte;
    logic [HIST_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    // Stream-cleared views of the state, as seen by the accepted byte
    phase_t             eff_phase;
    logic [7:0]         eff_held;
    logic [5:0]         eff_lit_left;
    logic               eff_finished;
    logic [HIST_AW-1:0] eff_wp;
    logic [16:0]        eff_pc;
    logic [11:0]        distance;
    logic               start_copy;
    logic               start_fill;
    status_t            st;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign out_free  = !m_valid_reg || m_ready;
    // Drain a full pair only while more bytes of the token are still to come
    assign emit_pair = (acc_n_reg == COUNT_TWO) && out_free &&
                       ((state_reg == S_COPY) || (state_reg == S_FILL));
    assign can_put   = (acc_n_reg != COUNT_TWO) || emit_pair;
    assign copy_byte = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign put       = ((state_reg == S_COPY) && rd_ok_reg && can_put) ||
                       ((state_reg == S_FILL) && can_put);
    assign put_byte  = (state_reg == S_COPY) ? copy_byte : fill_reg;
    // Advance the read address with each stored byte so the registered read has the next one ready
    assign ram_raddr = put ? (src_reg + HIST_AW'(1)) : src_reg;

    lzrd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (aclk),
        .we    (put),
        .waddr (wp_reg),
        .wdata (put_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eff_phase    = s_first_of_stream ? PH_TOKEN : phase_reg;
    assign eff_held     = s_first_of_stream ? 8'd0 : held_reg;
    assign eff_lit_left = s_first_of_stream ? 6'd0 : lit_left_reg;
    assign eff_finished = s_first_of_stream ? 1'b0 : finished_reg;
    assign eff_wp       = s_first_of_stream ? '0 : wp_reg;
    assign eff_pc       = s_first_of_stream ? 17'd0 : pc_reg;
    assign distance     = {eff_held[3:0], s_in_byte};

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        lit_left_next = lit_left_reg;
        finished_next = finished_reg;
        wp_next       = wp_reg;
        pc_next       = pc_reg;
        limit_next    = limit_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        rd_ok_next    = rd_ok_reg;
        fill_next     = fill_reg;
        status_next   = status_reg;
        acc_n_next    = acc_n_reg;
        acc_a_next    = acc_a_reg;
        acc_b_next    = acc_b_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_a_next = m_byte_a_reg;
        m_byte_b_next = m_byte_b_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        start_copy    = 1'b0;
        start_fill    = 1'b0;
        st            = ST_DATA;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        // Decode the accepted byte against the parse phase
        if (s_accept) begin
            phase_next    = eff_phase;
            held_next     = eff_held;
            lit_left_next = eff_lit_left;
            finished_next = eff_finished;
            wp_next       = eff_wp;
            pc_next       = eff_pc;
            if (!eff_finished) begin
                case (eff_phase)
                    PH_TOKEN: begin
                        if (eff_pc >= {1'b0, limit_reg}) begin
                            st = ST_LIMIT;
                        end else if (!s_in_byte[7]) begin
                            held_next  = s_in_byte;
                            phase_next = PH_DIST;
                        end else if (!s_in_byte[6]) begin
                            if (s_in_byte[5:0] == 6'd0) begin
                                st = ST_END;
                            end else begin
                                lit_left_next = s_in_byte[5:0];
                                phase_next    = PH_LIT;
                            end
                        end else begin
                            held_next  = s_in_byte;
                            phase_next = PH_FILL;
                        end
                    end
                    PH_DIST: begin
                        phase_next = PH_TOKEN;
                        if ((distance == 12'd0) || ({5'd0, distance} > eff_pc)) begin
                            st = ST_BAD;
                        end else begin
                            src_next   = eff_wp - HIST_AW'(distance);
                            cnt_next   = {4'd0, eff_held[6:4]} + 7'd3;
                            start_copy = 1'b1;
                        end
                    end
                    PH_LIT: begin
                        fill_next     = s_in_byte;
                        cnt_next      = 7'd1;
                        start_fill    = 1'b1;
                        lit_left_next = eff_lit_left - 6'd1;
                        if (eff_lit_left == 6'd1) begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    default: begin
                        fill_next  = s_in_byte;
                        cnt_next   = {1'b0, eff_held[5:0]} + 7'd3;
                        start_fill = 1'b1;
                        phase_next = PH_TOKEN;
                    end
                endcase
                if ((st == ST_DATA) && s_last_of_stream && (phase_next != PH_TOKEN)) begin
                    st = ST_TRUNC;
                end
                status_next = st;
                if (st != ST_DATA) begin
                    finished_next = 1'b1;
                end
                rd_ok_next = 1'b0;
                if (start_copy) begin
                    state_next = S_COPY;
                end else if (start_fill) begin
                    state_next = S_FILL;
                end else if (st != ST_DATA) begin
                    state_next = S_FLUSH;
                end
            end
        end

        // First read of a copy lands in the cycle after entry
        if (state_reg == S_COPY) begin
            rd_ok_next = 1'b1;
        end

        // Send a full pair ahead of the next byte
        if (emit_pair) begin
            m_valid_next  = 1'b1;
            m_byte_a_next = acc_a_reg;
            m_byte_b_next = acc_b_reg;
            m_count_next  = COUNT_TWO;
            m_last_next   = 1'b0;
            m_status_next = ST_DATA;
            acc_n_next    = COUNT_NONE;
        end

        // Store one decoded byte in history and in the pair accumulator
        if (put) begin
            wp_next  = wp_reg + HIST_AW'(1);
            pc_next  = pc_reg + 17'd1;
            cnt_next = cnt_reg - 7'd1;
            if (state_reg == S_COPY) begin
                src_next = src_reg + HIST_AW'(1);
            end
            if (emit_pair || (acc_n_reg == COUNT_NONE)) begin
                acc_a_next = put_byte;
                acc_n_next = COUNT_ONE;
            end else begin
                acc_b_next = put_byte;
                acc_n_next = COUNT_TWO;
            end
            if (cnt_reg == 7'd1) begin
                state_next = S_FLUSH;
            end
        end

        // Close the request: remaining bytes, then the status if any
        if (state_reg == S_FLUSH) begin
            if (acc_n_reg != COUNT_NONE) begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_byte_a_next = acc_a_reg;
                    m_byte_b_next = (acc_n_reg == COUNT_TWO) ? acc_b_reg : 8'd0;
                    m_count_next  = acc_n_reg;
                    m_last_next   = (status_reg == ST_DATA);
                    m_status_next = ST_DATA;
                    acc_n_next    = COUNT_NONE;
                    if (status_reg == ST_DATA) begin
                        state_next = S_IDLE;
                    end
                end
            end else if (status_reg != ST_DATA) begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_byte_a_next = 8'd0;
                    m_byte_b_next = 8'd0;
                    m_count_next  = COUNT_NONE;
                    m_last_next   = 1'b1;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end else begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_TOKEN;
            held_reg     <= 8'd0;
            lit_left_reg <= 6'd0;
            finished_reg <= 1'b0;
            wp_reg       <= '0;
            pc_reg       <= 17'd0;
            limit_reg    <= LIMIT_RESET;
            rd_ok_reg    <= 1'b0;
            status_reg   <= ST_DATA;
            acc_n_reg    <= COUNT_NONE;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            lit_left_reg <= lit_left_next;
            finished_reg <= finished_next;
            wp_reg       <= wp_next;
            pc_reg       <= pc_next;
            limit_reg    <= limit_next;
            rd_ok_reg    <= rd_ok_next;
            status_reg   <= status_next;
            acc_n_reg    <= acc_n_next;
            fwd_hit_reg  <= put && (wp_reg == ram_raddr);
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        src_reg      <= src_next;
        fill_reg     <= fill_next;
        acc_a_reg    <= acc_a_next;
        acc_b_reg    <= acc_b_next;
        fwd_data_reg <= put_byte;
        m_byte_a_reg <= m_byte_a_next;
        m_byte_b_reg <= m_byte_b_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_a     = m_byte_a_reg;
    assign m_byte_b     = m_byte_b_reg;
    assign m_byte_count = m_count_reg;
    assign m_run_last   = m_last_reg;
    assign m_status     = m_status_reg;

endmodule

>>> design/lzrd_checker.sv
// Port checker for the LZ/RLE token decompressor result channel, with its bind.
// Depends on lzrd_pkg and the top level lz_rle_token_decompressor.
module lzrd_checker
    import lzrd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_byte_a,
    input logic [7:0] m_byte_b,
    input logic [1:0] m_byte_count,
    input logic       m_run_last,
    input logic [2:0] m_status
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_a) && $stable(m_byte_b) &&
            $stable(m_byte_count) && $stable(m_status) && $stable(m_run_last))
        else $error("result changed while stalled");

    // A status result carries no bytes and closes its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_DATA) |-> (m_byte_count == COUNT_NONE) && m_run_last)
        else $error("status result malformed");

    // A data result carries one or two bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DATA) |->
            (m_byte_count == COUNT_ONE) || (m_byte_count == COUNT_TWO))
        else $error("data result without bytes");

    // Drop the second byte on a single-byte result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_byte_count == COUNT_ONE) |-> (m_byte_b == 8'd0))
        else $error("single-byte result malformed");

endmodule

bind lz_rle_token_decompressor lzrd_checker u_lzrd_checker (.*);

>>> tb/tb.sv
// Self-checking bench for the LZ/RLE token decompressor: drives packed byte requests,
// predicts every decoded pair and status result, and compares them as they leave the block.
// Depends on lzrd_pkg and lz_rle_token_decompressor only.
module tb;
    import lzrd_pkg::*;

    // Token byte forms of the packed stream
    localparam logic [7:0] TOK_LITERALS = 8'h80;  // 10nnnnnn, n literal bytes follow
    localparam logic [7:0] TOK_END      = 8'h80;  // literal token with n = 0
    localparam logic [7:0] TOK_FILL     = 8'hc0;  // 11nnnnnn, next byte repeated n + 3 times

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 125;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [1:0] byte_count;
        logic       run_last;
        status_t    status;
    } decoded_result_t;

    // Predicts the block's results and checks what it emits, oldest first.
    class decode_scoreboard;
        logic [7:0]          history [HIST_DEPTH];
        logic [HIST_AW-1:0]  wr_pos;
        logic [16:0]         produced;
        phase_t              phase;
        logic [7:0]          token;
        logic [5:0]          lits_left;
        bit                  stopped;
        logic [15:0]         out_limit;
        logic [7:0]          fresh_bytes[$];
        decoded_result_t     owed_results[$];
        int                  errors;

        function new();
            out_limit = LIMIT_RESET;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            wr_pos    = '0;
            produced  = '0;
            phase     = PH_TOKEN;
            token     = '0;
            lits_left = '0;
            stopped   = 1'b0;
        endfunction

        function void set_limit(logic [15:0] value);
            out_limit = value;
        endfunction

        function int waiting();
            return owed_results.size();
        endfunction

        function void store(logic [7:0] value);
            history[wr_pos] = value;
            wr_pos++;
            produced++;
            fresh_bytes.push_back(value);
        endfunction

        // Work out the results caused by one accepted request.
        function void decode_request(logic [7:0] b, logic first, logic last);
            status_t            st;
            logic [11:0]        distance;
            logic [HIST_AW-1:0] src;
            int                 n;
            decoded_result_t    r;
            decoded_result_t    batch[$];
            if (first)
                restart();
            if (stopped)
                return;
            fresh_bytes.delete();
            st = ST_DATA;
            case (phase)
                PH_TOKEN: begin
                    if (produced >= {1'b0, out_limit}) begin
                        st = ST_LIMIT;
                    end else if (!b[7]) begin
                        token = b;
                        phase = PH_DIST;
                    end else if (!b[6]) begin
                        if (b[5:0] == 6'd0) begin
                            st = ST_END;
                        end else begin
                            lits_left = b[5:0];
                            phase     = PH_LIT;
                        end
                    end else begin
                        token = b;
                        phase = PH_FILL;
                    end
                end
                PH_DIST: begin
                    distance = {token[3:0], b};
                    phase    = PH_TOKEN;
                    if (distance == 12'd0 || distance > produced) begin
                        st = ST_BAD;
                    end else begin
                        n = int'(token[6:4]) + 3;
                        repeat (n) begin
                            src = wr_pos - distance;
                            store(history[src]);
                        end
                    end
                end
                PH_LIT: begin
                    store(b);
                    lits_left--;
                    if (lits_left == 6'd0)
                        phase = PH_TOKEN;
                end
                default: begin
                    n = int'(token[5:0]) + 3;
                    repeat (n) store(b);
                    phase = PH_TOKEN;
                end
            endcase
            if (st == ST_DATA && last && phase != PH_TOKEN)
                st = ST_TRUNC;
            for (int k = 0; k < fresh_bytes.size(); k += 2) begin
                r        = '0;
                r.byte_a = fresh_bytes[k];
                if (k + 1 < fresh_bytes.size()) begin
                    r.byte_b     = fresh_bytes[k + 1];
                    r.byte_count = COUNT_TWO;
                end else begin
                    r.byte_count = COUNT_ONE;
                end
                r.status = ST_DATA;
                batch.push_back(r);
            end
            if (st != ST_DATA) begin
                r        = '0;
                r.status = st;
                batch.push_back(r);
                stopped  = 1'b1;
            end
            if (batch.size() > 0) begin
                r          = batch.pop_back();
                r.run_last = 1'b1;
                batch.push_back(r);
            end
            foreach (batch[i])
                owed_results.push_back(batch[i]);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(decoded_result_t got);
            decoded_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with nothing owed: a=%h b=%h count=%0d last=%0b st=%0d",
                                 got.byte_a, got.byte_b, got.byte_count, got.run_last,
                                 got.status));
                return;
            end
            want = owed_results.pop_front();
            if (got.byte_a !== want.byte_a)
                report($sformatf("byte_a %h, want %h", got.byte_a, want.byte_a));
            if (got.byte_b !== want.byte_b)
                report($sformatf("byte_b %h, want %h", got.byte_b, want.byte_b));
            if (got.byte_count !== want.byte_count)
                report($sformatf("byte_count %0d, want %0d", got.byte_count, want.byte_count));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        s_first_of_stream = 1'b0;
    logic        s_last_of_stream  = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_byte_a;
    logic [7:0]  m_byte_b;
    logic [1:0]  m_byte_count;
    logic        m_run_last;
    logic [2:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    decode_scoreboard sb;
    decoded_result_t  seen;

    // Stimulus bookkeeping
    logic [7:0] stream_q[$];   // packed bytes of the stream being built
    int         made;          // bytes the stream under construction should decode to
    int         sent = 0;      // requests accepted so far
    bit         quiet = 1'b0;  // no random sender gaps while set
    int         stall_left  = 0;
    int         steady_left = 0;

    lz_rle_token_decompressor DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_first_of_stream (s_first_of_stream),
        .s_last_of_stream  (s_last_of_stream),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_byte_a          (m_byte_a),
        .m_byte_b          (m_byte_b),
        .m_byte_count      (m_byte_count),
        .m_run_last        (m_run_last),
        .m_status          (m_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Watch all three handshakes at the edge. Note a request before checking results, so a
    // result can never overtake the request that caused it in the predictor.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_limit(cfg_data);
            if (s_valid && s_ready)
                sb.decode_request(s_in_byte, s_first_of_stream, s_last_of_stream);
            if (m_valid && m_ready) begin
                seen = '{m_byte_a, m_byte_b, m_byte_count, m_run_last, m_status};
                sb.check_result(seen);
            end
        end
    end

    // Result side backpressure: mostly ready, short stalls, rare long stalls, and
    // occasional long stretches with no stall at all.
    always @(posedge aclk) begin
        if (steady_left > 0) begin
            steady_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    steady_left = $urandom_range(40, 200);
                    m_ready <= 1'b1;
                end
                1: begin
                    stall_left = $urandom_range(10, 40);
                    m_ready <= 1'b0;
                end
                2, 3, 4, 5: begin
                    stall_left = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end
                default: m_ready <= 1'b1;
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Drop valid and hold until every owed result has left the block.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.waiting() != 0)
            @(posedge aclk);
    endtask

    // Drain, then give a request that causes no result time to finish its work.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write output_limit only with the block idle.
    task automatic write_limit(logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Send one packed byte request. Valid stays high into the next request when there is no
    // gap, so it is never lowered and raised in the same step.
    task automatic send_byte(logic [7:0] b, logic first, logic last);
        int gap;
        // Now and then, and once for sure, hold the sender until the block has drained.
        if (sent == 40 || $urandom_range(0, 39) == 0)
            drain_results();
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_in_byte         <= b;
        s_first_of_stream <= first;
        s_last_of_stream  <= last;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    function automatic void add_fill(int n);
        stream_q.push_back(TOK_FILL | 8'(n));
        stream_q.push_back(8'($urandom_range(0, 255)));
        made += n + 3;
    endfunction

    function automatic void add_copy(int cnt, int distance);
        stream_q.push_back({1'b0, 3'(cnt), 4'(distance >> 8)});
        stream_q.push_back(8'(distance));
        made += cnt + 3;
    endfunction

    function automatic void add_literals(int n);
        stream_q.push_back(TOK_LITERALS | 8'(n));
        repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
        made += n;
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 16'd1;
            1: return 16'($urandom_range(2, 300));
            2: return 16'hffff;
            default: return 16'($urandom_range(301, 65534));
        endcase
    endfunction

    task automatic send_stream(int last_at);
        foreach (stream_q[i])
            send_byte(stream_q[i], i == 0, i == last_at);
    endtask

    // One stream of well-formed tokens and noise bytes with random content, closed in one of several ways:
    // normal end, cut inside a token, bad distance, end marker, or simply restarted.
    task automatic random_stream();
        int  tokens;
        int  pick;
        int  n;
        int  ending;
        int  last_at;
        bit  closed;
        stream_q.delete();
        made    = 0;
        closed  = 1'b0;
        last_at = -1;
        quiet   = ($urandom_range(0, 4) == 0);
        tokens  = $urandom_range(1, 6);
        for (int t = 0; t < tokens && !closed; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_literals(($urandom_range(0, 7) == 0) ? 63 : $urandom_range(1, 5));
            end else if (pick < 55 || (pick < 85 && made == 0)) begin
                add_fill($urandom_range(0, 63));
            end else if (pick < 85) begin
                add_copy($urandom_range(0, 7), $urandom_range(1, made > 4095 ? 4095 : made));
            end else if (pick < 90) begin
                // zero distance or one reaching before the start of the output
                add_copy($urandom_range(0, 7), (made >= 4095 || $urandom_range(0, 1) == 0) ?
                         0 : $urandom_range(made + 1, 4095));
                closed = 1'b1;
            end else if (pick < 94) begin
                stream_q.push_back(TOK_END);
                closed = 1'b1;
            end else begin
                // noise: any byte at all
                stream_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        ending = $urandom_range(0, 9);
        if (!closed && ending >= 4 && ending < 7) begin
            // leave a token unfinished on the last byte
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(2, 63);
                    stream_q.push_back(TOK_LITERALS | 8'(n));
                    repeat ($urandom_range(0, n - 1))
                        stream_q.push_back(8'($urandom_range(0, 255)));
                end
                1: stream_q.push_back(TOK_FILL | 8'($urandom_range(0, 63)));
                default: stream_q.push_back(8'($urandom_range(0, 127)));
            endcase
            last_at = stream_q.size() - 1;
        end else if (ending < 4) begin
            last_at = stream_q.size() - 1;
        end
        send_stream(last_at);
        // a stray byte after the stream, often after a stop
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int streams;
        int random_start;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Two literals, overlapping copy of distance one, widest fill, far copy, end marker,
        // then a byte after the stop that must give nothing.
        send_byte(TOK_LITERALS | 8'd2, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte({1'b0, 3'd7, 4'h0}, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(TOK_FILL | 8'd63, 1'b0, 1'b0);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte({1'b0, 3'd3, 4'h0}, 1'b0, 1'b0);
        send_byte(8'd78, 1'b0, 1'b0);
        send_byte(TOK_END, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        // zero distance on restart
        send_byte({1'b0, 3'd4, 4'h0}, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        // largest distance, far beyond the output so far
        send_byte(TOK_LITERALS | 8'd1, 1'b1, 1'b0);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte({1'b0, 3'd0, 4'hf}, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        // fill byte owed on a single-byte stream
        send_byte(TOK_FILL | 8'd1, 1'b1, 1'b1);
        // literals cut short after one byte
        send_byte(TOK_LITERALS | 8'd3, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // distance byte owed
        send_byte({1'b0, 3'd1, 4'h2}, 1'b1, 1'b1);
        // last byte completes a token: no closing status
        send_byte(TOK_FILL, 1'b1, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1);
        // limit of one: the crossing token completes, the next one is refused
        write_limit(16'd1);
        send_byte(TOK_FILL | 8'd5, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(TOK_LITERALS | 8'd1, 1'b0, 1'b0);
        write_limit(16'hffff);

        streams      = 0;
        random_start = sent;
        while (sent - random_start < RANDOM_ITEMS) begin
            if (streams % 4 == 3) begin
                write_limit(pick_limit());
            end
            random_stream();
            streams++;
        end

        // Hold until everything owed has come out, then watch a little longer for strays.
        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
